// ===== rtl/gasp_pkg.sv =====
// gasp_pkg: shared types, widths and helper functions of the glyph atlas shelf placer
// no dependencies; used by gasp_core and glyph_atlas_shelf_placer_unit
package gasp_pkg;

  localparam int unsigned CoordW = 13;
  localparam int unsigned GlyphW = 8;
  localparam int unsigned RowW   = 8;
  localparam logic [RowW-1:0] RowHeightReset = 8'd16;
  localparam logic [CoordW-1:0] CoordMax = 13'h1FFF;

  typedef logic [CoordW-1:0] coord_t;

  // one result item
  typedef struct packed {
    coord_t atlas_height;
    coord_t atlas_width;
    logic   status;
    coord_t place_y;
    coord_t place_x;
  } gasp_result_t;

  // clamp a widened sum to the 13-bit coordinate range
  function automatic coord_t sat13(input logic [CoordW+1:0] v);
    coord_t r;
    if (v > {2'b00, CoordMax}) begin
      r = CoordMax;
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/glyph_atlas_shelf_placer_unit.sv =====
// glyph_atlas_shelf_placer_unit: top level with input register, config register and result register
// depends on gasp_pkg and gasp_core
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one glyph width per transfer (8 bits).
//   m_tvalid/m_tready/m_tdata/m_tuser carry one placement result per glyph.
//   cfg_valid/cfg_ready/cfg_data write row_height; cfg_ready is always high.
//   Write row_height only while no glyph is in flight.
// Path: a taken glyph is held in the input register, and its placement is then
//   registered into the result register, which raises m_tvalid.
// Throughput: one glyph per cycle while the result is not stalled; the placement is
//   a few adds and compares on the registered cursor, region and atlas state, combinational.
// Reset (rst, synchronous): empty pipeline, atlas not created, cursor and region
//   at the origin, region and atlas sides at INITIAL_SIDE, row_height 16.
// Stall: while m_tready is low the result holds; one more glyph can wait in the
//   input register, after which s_tready drops.
module glyph_atlas_shelf_placer_unit #(
  parameter int unsigned INITIAL_SIDE   = 32,
  parameter int unsigned MAX_ATLAS_SIDE = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,   // row_height
  // glyph input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // glyph_width[7:0]
  // placement result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,    // place_x[12:0], place_y[25:13], atlas_width[38:26],
                                  // atlas_height[51:39], zero[55:52]
  output logic        m_tuser     // status: 1 atlas full
);

  logic [gasp_pkg::RowW-1:0]   row_height;
  logic                        in_vld;
  logic [gasp_pkg::GlyphW-1:0] in_width;
  logic                        step;
  gasp_pkg::gasp_result_t      result;
  gasp_pkg::gasp_result_t      out_res;
  logic                        out_vld;

  // config register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      row_height <= gasp_pkg::RowHeightReset;
    end else if (cfg_valid) begin
      row_height <= cfg_data;
    end
  end

  // placement fires when a glyph is held and the result register is free
  assign step     = in_vld && (!out_vld || m_tready);
  assign s_tready = !in_vld || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_width <= s_tdata;
    end
  end

  gasp_core #(
    .INITIAL_SIDE  (INITIAL_SIDE),
    .MAX_ATLAS_SIDE(MAX_ATLAS_SIDE)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .glyph_width(in_width),
    .row_height (row_height),
    .result     (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (step) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= result;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tuser  = out_res.status;
  assign m_tdata  = {4'd0, out_res.atlas_height, out_res.atlas_width,
                     out_res.place_y, out_res.place_x};

endmodule

// ===== rtl/gasp_core.sv =====
// gasp_core: placement state registers and the combinational shelf placement logic
// depends on gasp_pkg
module gasp_core #(
  parameter int unsigned INITIAL_SIDE   = 32,
  parameter int unsigned MAX_ATLAS_SIDE = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [gasp_pkg::GlyphW-1:0]  glyph_width,
  input  logic [gasp_pkg::RowW-1:0]    row_height,
  output gasp_pkg::gasp_result_t       result
);

  localparam gasp_pkg::coord_t InitSide = gasp_pkg::sat13(15'(INITIAL_SIDE));
  localparam logic [14:0] MaxSide = 15'(MAX_ATLAS_SIDE);

  // placement state
  logic            atlas_created;
  gasp_pkg::coord_t cursor_x, cursor_y, region_x, region_y, region_w, region_h;
  gasp_pkg::coord_t tex_w, tex_h;

  logic            atlas_created_next;
  gasp_pkg::coord_t cursor_x_next, cursor_y_next, region_x_next, region_y_next;
  gasp_pkg::coord_t region_w_next, region_h_next, tex_w_next, tex_h_next;

  // widened sums shared by the checks
  logic [13:0] x_extent, y_extent, y_row, right, bottom;
  logic [14:0] grown, grow_src;
  logic        grow, over, row_fits, full;
  gasp_pkg::coord_t grown_side, cx_mid, cy_mid;

  assign x_extent = {1'b0, cursor_x} + 14'(glyph_width);
  assign y_extent = {1'b0, cursor_y} + {5'd0, row_height, 1'b0};
  assign y_row    = {1'b0, cursor_y} + 14'(row_height);
  assign right    = {1'b0, region_x} + {1'b0, region_w};
  assign bottom   = {1'b0, region_y} + {1'b0, region_h};

  // atlas growth: double width when square, else height
  assign grow     = atlas_created && (x_extent > {1'b0, tex_w}) && (y_extent > {1'b0, tex_h});
  assign grow_src = (tex_w == tex_h) ? {1'b0, tex_w, 1'b0} : {1'b0, tex_h, 1'b0};
  assign grown    = (grow_src > MaxSide) ? MaxSide : grow_src;
  assign grown_side = gasp_pkg::sat13(grown);

  always_comb begin
    atlas_created_next = 1'b1;
    tex_w_next = tex_w;
    tex_h_next = tex_h;
    if (grow) begin
      if (tex_w == tex_h) begin
        tex_w_next = grown_side;
      end else begin
        tex_h_next = grown_side;
      end
    end
  end

  // region and row moves
  assign over     = x_extent > right;
  assign row_fits = y_extent <= bottom;

  always_comb begin
    region_x_next = region_x;
    region_y_next = region_y;
    region_w_next = region_w;
    region_h_next = region_h;
    cx_mid = cursor_x;
    cy_mid = cursor_y;
    full = 1'b0;
    if (over) begin
      if (row_fits) begin
        cx_mid = region_x;
        cy_mid = gasp_pkg::sat13({1'b0, y_row});
      end else if ((right < {1'b0, tex_w_next}) && (right == bottom)) begin
        region_x_next = gasp_pkg::sat13({1'b0, right});
        region_y_next = '0;
        region_h_next = region_w;
        cx_mid = gasp_pkg::sat13({1'b0, right});
        cy_mid = '0;
      end else if (bottom < {1'b0, tex_h_next}) begin
        region_x_next = '0;
        region_w_next = gasp_pkg::sat13({1'b0, region_w, 1'b0});
        region_y_next = gasp_pkg::sat13({1'b0, bottom});
        cx_mid = '0;
        cy_mid = gasp_pkg::sat13({1'b0, bottom});
      end else begin
        full = 1'b1;
      end
    end
  end

  // result and cursor advance; a full atlas keeps cursor and region
  always_comb begin
    result.atlas_width  = tex_w_next;
    result.atlas_height = tex_h_next;
    result.status       = full;
    if (full) begin
      result.place_x = '0;
      result.place_y = '0;
      cursor_x_next  = cursor_x;
      cursor_y_next  = cursor_y;
    end else begin
      result.place_x = cx_mid;
      result.place_y = cy_mid;
      cursor_x_next  = gasp_pkg::sat13({2'b00, cx_mid} + 15'(glyph_width));
      cursor_y_next  = cy_mid;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_created <= 1'b0;
      cursor_x <= '0;
      cursor_y <= '0;
      region_x <= '0;
      region_y <= '0;
      region_w <= InitSide;
      region_h <= InitSide;
      tex_w    <= InitSide;
      tex_h    <= InitSide;
    end else if (step) begin
      atlas_created <= atlas_created_next;
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
      region_x <= full ? region_x : region_x_next;
      region_y <= full ? region_y : region_y_next;
      region_w <= full ? region_w : region_w_next;
      region_h <= full ? region_h : region_h_next;
      tex_w    <= tex_w_next;
      tex_h    <= tex_h_next;
    end
  end

endmodule

// ===== rtl/gasp_checker.sv =====
// gasp_checker: port-level assertions for glyph_atlas_shelf_placer_unit, with its bind
// depends on the top level's port list only
module gasp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tuser
);

  logic [12:0] aw, ah;
  assign aw = m_tdata[38:26];
  assign ah = m_tdata[51:39];

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // a stalled result stays valid and unchanged
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a full atlas reports the origin as placement
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[25:0] == 26'd0)
    else $error("full result with nonzero placement");

  // growth alternates sides, so width stays between height and twice height
  a_aspect: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (aw >= ah) && ({1'b0, aw} <= {ah, 1'b0}))
    else $error("atlas aspect out of range");

endmodule

bind glyph_atlas_shelf_placer_unit gasp_checker u_gasp_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
